FILE: hdl/pfkp_pkg.sv
// package: types, constants and helpers for the flow key parser
`timescale 1ns / 1ps
`default_nettype none
package pfkp_pkg;

  localparam int unsigned MaxLayersDef  = 4;
  localparam int unsigned OffsetBitsDef = 16;

  localparam logic [15:0] EthPIp     = 16'h0800;
  localparam logic [15:0] EthPIpv6   = 16'h86DD;
  localparam logic [15:0] EthP8021q  = 16'h8100;
  localparam logic [15:0] EthPPppSes = 16'h8864;
  localparam logic [15:0] PppIp      = 16'h0021;
  localparam logic [15:0] PppIpv6    = 16'h0057;
  localparam logic [7:0]  IpprotoGre  = 8'd47;
  localparam logic [7:0]  IpprotoIpip = 8'd4;
  localparam logic [7:0]  IpprotoAh   = 8'd51;
  localparam logic [7:0]  IpprotoTcp     = 8'd6;
  localparam logic [7:0]  IpprotoUdp     = 8'd17;
  localparam logic [7:0]  IpprotoDccp    = 8'd33;
  localparam logic [7:0]  IpprotoEsp     = 8'd50;
  localparam logic [7:0]  IpprotoSctp    = 8'd132;
  localparam logic [7:0]  IpprotoUdplite = 8'd136;
  localparam logic [15:0] GreCsum    = 16'h8000;
  localparam logic [15:0] GreRouting = 16'h4000;
  localparam logic [15:0] GreKey     = 16'h2000;
  localparam logic [15:0] GreSeq     = 16'h1000;
  localparam logic [15:0] GreVersion = 16'h0007;

  localparam logic [3:0] PhIdle  = 4'd0;
  localparam logic [3:0] PhVlan  = 4'd1;
  localparam logic [3:0] PhPppoe = 4'd2;
  localparam logic [3:0] PhIpv4  = 4'd3;
  localparam logic [3:0] PhIpv6  = 4'd4;
  localparam logic [3:0] PhGre   = 4'd5;
  localparam logic [3:0] PhPorts = 4'd6;
  localparam logic [3:0] PhDone  = 4'd7;
  localparam logic [3:0] PhFail  = 4'd8;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        first_byte;
    logic        last_byte;
    logic [15:0] ethertype;
  } in_word_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [31:0] ports;
    logic [7:0]  l4_proto;
  } out_word_t;

endpackage
`default_nettype wire

FILE: hdl/pfkp_out_reg.sv
// output register with skid stage for result words
`timescale 1ns / 1ps
`default_nettype none
module pfkp_out_reg (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   valid_i,
  input  pfkp_pkg::out_word_t   word_i,
  output logic                  stall_o,
  output logic                  valid_o,
  input  wire                   stall_i,
  output pfkp_pkg::out_word_t   word_o
);

  logic                valid_q, skid_q;
  pfkp_pkg::out_word_t word_q, skid_word_q;

  assign valid_o = valid_q;
  assign word_o  = word_q;
  assign stall_o = skid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      skid_q  <= 1'b0;
    end else begin
      if (!valid_q || !stall_i) begin
        if (skid_q) begin
          valid_q <= 1'b1;
          skid_q  <= 1'b0;
        end else begin
          valid_q <= valid_i;
        end
      end else if (valid_i && !skid_q) begin
        skid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!valid_q || !stall_i) begin
      word_q <= skid_q ? skid_word_q : word_i;
    end else if (valid_i && !skid_q) begin
      skid_word_q <= word_i;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/pfkp_parse.sv
// per-byte header walk and key capture
`timescale 1ns / 1ps
`default_nettype none
module pfkp_parse #(
  parameter int unsigned MaxLayers  = pfkp_pkg::MaxLayersDef,
  parameter int unsigned OffsetBits = pfkp_pkg::OffsetBitsDef
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  take_i,
  input  pfkp_pkg::in_word_t   word_i,
  output logic                 res_valid_o,
  output pfkp_pkg::out_word_t  res_o
);

  localparam logic [OffsetBits-1:0] PosMax = {OffsetBits{1'b1}};
  localparam logic [2:0] LayerLim = 3'(MaxLayers);

  logic [OffsetBits-1:0] pos_q, pos_d, hs_q, hs_d;
  logic [3:0]  ph_q, ph_d;
  logic [31:0] fc_q, fc_d, dc_q, dc_d;
  logic [15:0] gre_q, gre_d;
  logic [2:0]  lc_q, lc_d;
  logic [31:0] ks_q, ks_d, kd_q, kd_d, kp_q, kp_d;
  logic [7:0]  kproto_q, kproto_d, l4_q, l4_d;
  logic        fail_q, fail_d;
  logic [3:0]  ihl_q, ihl_d;
  logic        frag_q, frag_d;

  function automatic logic [OffsetBits-1:0] sat_add(logic [OffsetBits-1:0] a,
                                                    logic [6:0] b);
    logic [OffsetBits:0] s;
    s = {1'b0, a} + (OffsetBits+1)'(b);
    return s[OffsetBits] ? PosMax : s[OffsetBits-1:0];
  endfunction

  always_comb begin
    logic [OffsetBits-1:0] off;
    logic [OffsetBits-1:0] nxt;
    logic [15:0] p16;
    logic [7:0]  l4;
    logic [6:0]  glen;
    logic        do_start, do_final, is_gre;
    logic [3:0]  start_kind;
    logic [7:0]  fin_proto;
    pos_d = pos_q; hs_d = hs_q; ph_d = ph_q; fc_d = fc_q; dc_d = dc_q;
    gre_d = gre_q; lc_d = lc_q; ks_d = ks_q; kd_d = kd_q; kp_d = kp_q;
    kproto_d = kproto_q; l4_d = l4_q; fail_d = fail_q; ihl_d = ihl_q;
    frag_d = frag_q;
    res_valid_o = 1'b0;
    off = '0; nxt = '0; p16 = '0; l4 = '0; glen = 7'd4;
    do_start = 1'b0; do_final = 1'b0; is_gre = 1'b0; start_kind = pfkp_pkg::PhFail;
    fin_proto = '0;
    res_o = '0;
    if (take_i) begin
      if (word_i.first_byte) begin
        pos_d = '0; hs_d = '0; fc_d = '0; dc_d = '0; gre_d = '0; lc_d = '0;
        ks_d = '0; kd_d = '0; kp_d = '0; kproto_d = '0; l4_d = '0;
        fail_d = 1'b0; ihl_d = '0; frag_d = 1'b0;
        p16 = word_i.ethertype;
        do_start = 1'b1;
        nxt = '0;
        case (p16)
          pfkp_pkg::EthPIp:     start_kind = pfkp_pkg::PhIpv4;
          pfkp_pkg::EthPIpv6:   start_kind = pfkp_pkg::PhIpv6;
          pfkp_pkg::EthP8021q:  start_kind = pfkp_pkg::PhVlan;
          pfkp_pkg::EthPPppSes: start_kind = pfkp_pkg::PhPppoe;
          default:              start_kind = pfkp_pkg::PhFail;
        endcase
        // first-byte dispatch applied directly (layer count is zero)
        if (start_kind == pfkp_pkg::PhFail || LayerLim == 3'd0) begin
          ph_d = pfkp_pkg::PhFail; fail_d = 1'b1;
        end else begin
          ph_d = start_kind; lc_d = 3'd1; hs_d = '0;
        end
        do_start = 1'b0;
      end
      if (ph_d != pfkp_pkg::PhIdle) begin
        if (ph_d != pfkp_pkg::PhDone && ph_d != pfkp_pkg::PhFail) begin
          if (pos_d >= PosMax) begin
            if (ph_d == pfkp_pkg::PhPorts) ph_d = pfkp_pkg::PhDone;
            else begin ph_d = pfkp_pkg::PhFail; fail_d = 1'b1; end
          end else if (pos_d >= hs_d) begin
            off = pos_d - hs_d;
            case (ph_d)
              pfkp_pkg::PhVlan: begin
                if (off == 2) fc_d = {24'd0, word_i.data_byte};
                else if (off == 3) begin
                  p16 = {fc_d[7:0], word_i.data_byte};
                  nxt = sat_add(hs_d, 7'd4);
                  do_start = 1'b1;
                end
              end
              pfkp_pkg::PhPppoe: begin
                if (off == 6) fc_d = {24'd0, word_i.data_byte};
                else if (off == 7) begin
                  nxt = sat_add(hs_d, 7'd8);
                  do_start = 1'b1;
                  if ({fc_d[7:0], word_i.data_byte} == pfkp_pkg::PppIp)
                    p16 = pfkp_pkg::EthPIp;
                  else if ({fc_d[7:0], word_i.data_byte} == pfkp_pkg::PppIpv6)
                    p16 = pfkp_pkg::EthPIpv6;
                  else p16 = '0;
                end
              end
              pfkp_pkg::PhIpv4: begin
                if (off == 0) begin
                  ihl_d = word_i.data_byte[3:0]; frag_d = 1'b0;
                end else if (off == 6) frag_d = word_i.data_byte[5:0] != 6'd0;
                else if (off == 7) begin
                  if (word_i.data_byte != 8'd0) frag_d = 1'b1;
                end else if (off == 9) l4_d = word_i.data_byte;
                else if (off >= 12 && off <= 15)
                  fc_d = {fc_d[23:0], word_i.data_byte};
                else if (off >= 16 && off <= 19) begin
                  dc_d = {dc_d[23:0], word_i.data_byte};
                  if (off == 19) begin
                    if (ihl_d < 4'd5) begin
                      ph_d = pfkp_pkg::PhFail; fail_d = 1'b1;
                    end else begin
                      ks_d = fc_d; kd_d = dc_d;
                      l4 = frag_d ? 8'd0 : l4_d;
                      nxt = sat_add(hs_d, {1'b0, ihl_d, 2'b00});
                      if (l4 == pfkp_pkg::IpprotoGre) begin
                        do_start = 1'b1; is_gre = 1'b1;
                      end else if (l4 == pfkp_pkg::IpprotoIpip) begin
                        do_start = 1'b1; p16 = pfkp_pkg::EthPIp;
                      end else begin
                        do_final = 1'b1; fin_proto = l4;
                      end
                    end
                  end
                end
              end
              pfkp_pkg::PhIpv6: begin
                if (off == 6) l4_d = word_i.data_byte;
                else if (off >= 20 && off <= 23)
                  fc_d = {fc_d[23:0], word_i.data_byte};
                else if (off >= 36 && off <= 39) begin
                  dc_d = {dc_d[23:0], word_i.data_byte};
                  if (off == 39) begin
                    ks_d = fc_d; kd_d = dc_d;
                    l4 = l4_d;
                    nxt = sat_add(hs_d, 7'd40);
                    if (l4 == pfkp_pkg::IpprotoGre) begin
                      do_start = 1'b1; is_gre = 1'b1;
                    end else if (l4 == pfkp_pkg::IpprotoIpip) begin
                      do_start = 1'b1; p16 = pfkp_pkg::EthPIp;
                    end else begin
                      do_final = 1'b1; fin_proto = l4;
                    end
                  end
                end
              end
              pfkp_pkg::PhGre: begin
                if (off <= 1) gre_d = {gre_d[7:0], word_i.data_byte};
                else if (off == 2) fc_d = {24'd0, word_i.data_byte};
                else if (off == 3) begin
                  if ((gre_d & (pfkp_pkg::GreVersion | pfkp_pkg::GreRouting)) != 16'd0)
                  begin
                    do_final = 1'b1; fin_proto = pfkp_pkg::IpprotoGre;
                    nxt = sat_add(hs_d, 7'd4);
                  end else begin
                    glen = 7'd4 + ((gre_d & pfkp_pkg::GreCsum) != 0 ? 7'd4 : 7'd0)
                         + ((gre_d & pfkp_pkg::GreKey) != 0 ? 7'd4 : 7'd0)
                         + ((gre_d & pfkp_pkg::GreSeq) != 0 ? 7'd4 : 7'd0);
                    nxt = sat_add(hs_d, glen);
                    p16 = {fc_d[7:0], word_i.data_byte};
                    do_start = 1'b1;
                  end
                end
              end
              pfkp_pkg::PhPorts: begin
                fc_d = {fc_d[23:0], word_i.data_byte};
                if (off == 3) begin
                  kp_d = fc_d; ph_d = pfkp_pkg::PhDone;
                end
              end
              default: ;
            endcase
            if (do_start) begin
              if (is_gre) start_kind = pfkp_pkg::PhGre;
              else begin
                case (p16)
                  pfkp_pkg::EthPIp:     start_kind = pfkp_pkg::PhIpv4;
                  pfkp_pkg::EthPIpv6:   start_kind = pfkp_pkg::PhIpv6;
                  pfkp_pkg::EthP8021q:  start_kind = pfkp_pkg::PhVlan;
                  pfkp_pkg::EthPPppSes: start_kind = pfkp_pkg::PhPppoe;
                  default:              start_kind = pfkp_pkg::PhFail;
                endcase
              end
              if (start_kind == pfkp_pkg::PhFail || lc_d >= LayerLim) begin
                ph_d = pfkp_pkg::PhFail; fail_d = 1'b1;
              end else begin
                ph_d = start_kind; lc_d = lc_d + 3'd1; hs_d = nxt; fc_d = '0;
              end
            end
            if (do_final) begin
              kproto_d = fin_proto;
              case (fin_proto)
                pfkp_pkg::IpprotoTcp, pfkp_pkg::IpprotoUdp, pfkp_pkg::IpprotoDccp,
                pfkp_pkg::IpprotoEsp, pfkp_pkg::IpprotoSctp,
                pfkp_pkg::IpprotoUdplite: begin
                  ph_d = pfkp_pkg::PhPorts; hs_d = nxt; fc_d = '0;
                end
                pfkp_pkg::IpprotoAh: begin
                  ph_d = pfkp_pkg::PhPorts; hs_d = sat_add(nxt, 7'd4); fc_d = '0;
                end
                default: ph_d = pfkp_pkg::PhDone;
              endcase
            end
          end
        end
        pos_d = (pos_d == PosMax) ? PosMax : pos_d + 1'b1;
        if (word_i.last_byte) begin
          if (ph_d != pfkp_pkg::PhPorts && ph_d != pfkp_pkg::PhDone) fail_d = 1'b1;
          res_valid_o    = 1'b1;
          res_o.ok       = !fail_d;
          res_o.src_addr = ks_d;
          res_o.dst_addr = kd_d;
          res_o.ports    = kp_d;
          res_o.l4_proto = kproto_d;
          ph_d = pfkp_pkg::PhIdle;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0; hs_q <= '0; ph_q <= pfkp_pkg::PhIdle; fc_q <= '0; dc_q <= '0;
      gre_q <= '0; lc_q <= '0; ks_q <= '0; kd_q <= '0; kp_q <= '0;
      kproto_q <= '0; l4_q <= '0; fail_q <= 1'b0; ihl_q <= '0; frag_q <= 1'b0;
    end else begin
      pos_q <= pos_d; hs_q <= hs_d; ph_q <= ph_d; fc_q <= fc_d; dc_q <= dc_d;
      gre_q <= gre_d; lc_q <= lc_d; ks_q <= ks_d; kd_q <= kd_d; kp_q <= kp_d;
      kproto_q <= kproto_d; l4_q <= l4_d; fail_q <= fail_d; ihl_q <= ihl_d;
      frag_q <= frag_d;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/packet_flow_key_parser_core.sv
// top level of the streaming five-tuple flow key parser
// usage: packet bytes enter on the in channel one word per cycle while in_stall_o is low, starting at
// the network header with first_byte set and the link ethertype alongside.
// an input word is taken when in_valid_i is high and in_stall_o is low.
// the header walk updates its state in the same cycle a byte is taken, so
// one byte per cycle is sustained while in_stall_o is low; the state registers set the rate.
// on the byte with last_byte set, one result word (keys and ok flag) goes to
// the output register (via the skid stage under a stall) and drives out_valid_o.
// a result is taken when out_valid_o is high and out_stall_i is low.
// when the receiver stalls, the held result stays put and one more result
// fits in a skid stage; in_stall_o rises only while that skid stage is full.
// bytes outside a packet are dropped without a result.
// reset clears the parse state and empties both output stages.
`timescale 1ns / 1ps
`default_nettype none
module packet_flow_key_parser_core #(
  parameter int unsigned MaxLayers  = pfkp_pkg::MaxLayersDef,
  parameter int unsigned OffsetBits = pfkp_pkg::OffsetBitsDef
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_stall_o,
  input  pfkp_pkg::in_word_t   in_word_i,
  output logic                 out_valid_o,
  input  wire                  out_stall_i,
  output pfkp_pkg::out_word_t  out_word_o
);

  logic                take;
  logic                res_valid;
  pfkp_pkg::out_word_t res;

  assign take = in_valid_i && !in_stall_o;

  pfkp_parse #(
    .MaxLayers (MaxLayers),
    .OffsetBits(OffsetBits)
  ) u_parse (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .take_i     (take),
    .word_i     (in_word_i),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  pfkp_out_reg u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(res_valid),
    .word_i (res),
    .stall_o(in_stall_o),
    .valid_o(out_valid_o),
    .stall_i(out_stall_i),
    .word_o (out_word_o)
  );

endmodule
`default_nettype wire
